### hw/rtl/tsf_pkg.sv
`default_nettype none

package tsf_pkg;

  // fixed field widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned SEG_W  = 8;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [SEG_W-1:0]  DP_BIT    = 8'h80;
  localparam logic [SEG_W-1:0]  BLANK_SEG = 8'h00;

  localparam logic [SEG_W-1:0] DIGIT_FONT [0:9] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h73
  };

  localparam logic [SEG_W-1:0] LETTER_FONT [0:25] = '{
    8'h77, 8'h7F, 8'h4E, 8'h7E, 8'h4F, 8'h47, 8'h5F, 8'h37, 8'h06, 8'h3C,
    8'h37, 8'h0E, 8'h54, 8'h76, 8'h7E, 8'h67, 8'hFE, 8'h66, 8'h5B, 8'h07,
    8'h3E, 8'h1C, 8'h2A, 8'h37, 8'h3B, 8'h6D
  };

  // frames owed for one accepted character
  typedef struct packed {
    logic             valid;
    logic             has_a;
    logic [SEG_W-1:0] seg_a;
    logic             has_b;
    logic [SEG_W-1:0] seg_b;
    logic             is_end;
  } job_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d_off;
    logic [CHAR_W-1:0] l_off;
    logic [SEG_W-1:0]  g;
    d_off = c - 8'h30;
    l_off = c - 8'h41;
    if (c >= 8'h30 && c <= 8'h39) begin
      g = DIGIT_FONT[d_off[3:0]];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g = LETTER_FONT[l_off[4:0]];
    end else if (c == 8'h2D) begin
      g = 8'h01;
    end else if (c == 8'h21) begin
      g = 8'hA0;
    end else begin
      g = BLANK_SEG;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/tsf_front.sv
`default_nettype none

// holds one character back and turns each accepted character into a job
module tsf_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [tsf_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                        end_of_text,
  output tsf_pkg::job_t                    job
);

  logic [tsf_pkg::CHAR_W-1:0] held_char_r, held_char_nxt;
  logic                       held_valid_r, held_valid_nxt;
  logic [tsf_pkg::CHAR_W-1:0] after_char;
  logic                       after_valid;
  logic                       is_dot;

  assign is_dot = (char_code == tsf_pkg::DOT_CHAR);

  always_comb begin
    job         = '0;
    after_char  = char_code;
    after_valid = 1'b1;
    if (held_valid_r) begin
      job.has_a = 1'b1;
      if (is_dot) begin
        job.seg_a   = tsf_pkg::glyph(held_char_r) | tsf_pkg::DP_BIT;
        after_char  = '0;
        after_valid = 1'b0;
      end else begin
        job.seg_a = tsf_pkg::glyph(held_char_r);
      end
    end
    // held character after this one is always the incoming one when valid
    job.has_b  = end_of_text && after_valid;
    job.seg_b  = tsf_pkg::glyph(char_code);
    job.is_end = end_of_text;
    job.valid  = job.has_a || end_of_text;

    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    if (accept) begin
      if (end_of_text) begin
        held_char_nxt  = '0;
        held_valid_nxt = 1'b0;
      end else begin
        held_char_nxt  = after_char;
        held_valid_nxt = after_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tsf_frame.sv
`default_nettype none

// job register, position counter and output register
module tsf_frame #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire tsf_pkg::job_t             job,
  output logic                           job_free,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [tsf_pkg::POS_W-1:0]      digit_position,
  output logic [tsf_pkg::SEG_W-1:0]      segment_byte,
  output logic                           last_frame
);

  localparam logic [tsf_pkg::POS_W-1:0] LAST_POS = tsf_pkg::POS_W'(NUM_DIGITS);

  tsf_pkg::job_t                job_r, job_nxt;
  logic [tsf_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tsf_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [tsf_pkg::SEG_W-1:0]    out_seg_r, out_seg_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         out_free;
  logic                         step;
  logic                         full;
  logic [tsf_pkg::POS_W-1:0]    pos_inc;
  logic                         at_last;
  logic                         more;
  logic                         done;

  assign out_free = !out_valid_r || out_tready;
  assign step     = job_r.valid && out_free;
  assign full     = (pos_r >= LAST_POS);
  assign pos_inc  = pos_r + 4'd1;
  assign at_last  = (pos_inc == LAST_POS);

  always_comb begin
    // what is still owed after the current frame
    if (job_r.has_a) begin
      more = job_r.has_b || job_r.is_end;
    end else begin
      more = job_r.is_end;
    end
    done = full || at_last || !more;
    job_free = !job_r.valid || (step && done);

    job_nxt       = job_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_seg_nxt   = out_seg_r;
    out_last_nxt  = out_last_r;

    if (step) begin
      if (full) begin
        // digit overflow: drop whatever is left of this job
        if (job_r.is_end) begin
          pos_nxt = '0;
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = pos_inc;
        out_last_nxt  = at_last;
        if (job_r.has_a) begin
          out_seg_nxt = job_r.seg_a;
        end else if (job_r.has_b) begin
          out_seg_nxt = job_r.seg_b;
        end else begin
          out_seg_nxt = tsf_pkg::BLANK_SEG;
        end
        if (at_last && job_r.is_end) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      if (job_r.has_a) begin
        job_nxt.has_a = 1'b0;
      end else begin
        job_nxt.has_b = 1'b0;
      end
      if (done) begin
        job_nxt.valid = 1'b0;
      end
    end

    if (accept && job.valid) begin
      job_nxt = job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_r       <= job_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r  <= out_pos_nxt;
    out_seg_r  <= out_seg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid     = out_valid_r;
  assign digit_position = out_pos_r;
  assign segment_byte   = out_seg_r;
  assign last_frame     = out_last_r;

endmodule

`default_nettype wire

### hw/rtl/text_to_seven_segment_frames_core.sv
`default_nettype none

// text to seven-segment display frames
// input stream: one ascii character per transaction, in_tlast on the last
// character of a string; strings are at least one character long
// output stream: one display frame per transaction, digit position 1 to
// NUM_DIGITS, segment byte (bit 7 decimal point) and the packed frame word;
// out_tlast marks the frame at position NUM_DIGITS, which closes a string
// one character is held back so a following '.' can become its decimal point;
// the first character of a string therefore yields no frame unless it closes it
// a frame passes through the job register and then the output register
// before it shows on out_tvalid; further frames owed follow one per cycle
// while out_tready is high; one character per cycle when not stalled, but a
// closing character holds in_tready low until it has stepped out every frame
// it still owes (held digit, flush, blank padding up to NUM_DIGITS)
// digits beyond NUM_DIGITS are dropped without a frame
// reset clears the held character, the job register, the position counter
// and the output valid flag; when the receiver stalls the frame stays on
// out_tdata and in_tready stays low while the pending job cannot finish in this cycle
module text_to_seven_segment_frames_core #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [tsf_pkg::OUT_TDATA_W-1:0] out_tdata,  // [3:0] digit_position,
                                       // [11:4] segment_byte,
                                       // [27:12] frame_word, [31:28] zero
  output logic             out_tlast   // last_frame
);

  tsf_pkg::job_t                 job;
  logic                          job_free;
  logic                          accept;
  logic [tsf_pkg::POS_W-1:0]     digit_position;
  logic [tsf_pkg::SEG_W-1:0]     segment_byte;
  logic [tsf_pkg::WORD_W-1:0]    frame_word;

  // a new character may enter whenever the job register frees this cycle
  assign in_tready = job_free;
  assign accept    = in_tvalid && job_free;

  // lookahead and font lookup
  tsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .job         (job)
  );

  // frame sequencing and output register
  tsf_frame #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .job            (job),
    .job_free       (job_free),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .digit_position (digit_position),
    .segment_byte   (segment_byte),
    .last_frame     (out_tlast)
  );

  // position in the high byte, segments in the low byte
  assign frame_word = {4'd0, digit_position, segment_byte};
  assign out_tdata  = {4'd0, frame_word, segment_byte, digit_position};

endmodule

`default_nettype wire

### hw/rtl/tsf_checker.sv
`default_nettype none

module tsf_checker #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // position the next frame must carry
  logic [3:0] next_pos_r, next_pos_nxt;

  always_comb begin
    next_pos_nxt = next_pos_r;
    if (out_tvalid && out_tready) begin
      next_pos_nxt = out_tlast ? 4'd1 : out_tdata[3:0] + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_pos_r <= 4'd1;
    end else begin
      next_pos_r <= next_pos_nxt;
    end
  end

  // a stalled frame holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled frame changed");

  // frame word agrees with position and segment fields
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:12] == out_tdata[11:4] && out_tdata[23:20] == out_tdata[3:0]
                   && out_tdata[31:24] == 8'd0)
    else $error("frame word mismatch");

  // position in range, last flag exactly at the final position
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] != 4'd0 && out_tdata[3:0] <= 4'(NUM_DIGITS)
                   && out_tlast == (out_tdata[3:0] == 4'(NUM_DIGITS)))
    else $error("bad digit position");

  // positions advance by one within a string and restart after the last frame
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] == next_pos_r)
    else $error("digit position out of sequence");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("frame valid after reset");

endmodule

bind text_to_seven_segment_frames_core tsf_checker #(
  .NUM_DIGITS (NUM_DIGITS)
) u_tsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
